// ===== rtl/rcsp_pkg.sv =====
package rcsp_pkg;

	// List stack
	localparam int LIST_DEPTH = 8;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	// Event queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Header layout
	localparam logic [3:0]  TAG_LEN        = 4'd4;
	localparam logic [3:0]  CHUNK_HDR_LEN  = 4'd8;
	localparam logic [3:0]  LIST_HDR_LEN   = 4'd12;
	localparam logic [31:0] DATA_OFFSET    = 32'd8;
	localparam logic [31:0] TAG_RIFF       = 32'h4646_4952;
	localparam logic [31:0] TAG_LIST       = 32'h5453_494C;

	typedef enum logic [2:0] {
		EV_FILE     = 3'd0,
		EV_LIST     = 3'd1,
		EV_CHUNK    = 3'd2,
		EV_PAYLOAD  = 3'd3,
		EV_NOT_RIFF = 3'd4
	} event_kind_t;

	typedef struct packed {
		event_kind_t kind;
		logic [31:0] id;
		logic [31:0] size;
		logic [31:0] offset;
		logic [31:0] form;
		logic [31:0] hstart;
		logic [7:0]  pbyte;
		logic        plast;
	} event_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

// ===== rtl/rcsp_front.sv =====
module rcsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                start_of_file,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                emit_payload,
	input  rcsp_pkg::q_status_t q_status,
	output logic                q_push,
	output rcsp_pkg::event_t    q_item
);

	typedef enum logic [3:0] {
		PH_WAIT    = 4'b0001,
		PH_FILE    = 4'b0010,
		PH_HEADER  = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	phase_t           phase_q, phase_eff, phase_n;
	logic [31:0]      pos_q, pos_eff;
	logic [3:0]       hcnt_q, hcnt_eff, hcnt_inc, hcnt_n;
	logic [31:0]      rem_q, rem_eff, rem_n;
	logic [31:0]      hstart_q, hstart_n;
	logic [95:0]      hbuf_q, hbuf_n;
	logic [31:0]      w0, w1, w2;
	logic             emit_q;
	logic             accept;
	logic             push;
	rcsp_pkg::event_t item;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_status.full;
	assign accept    = in_valid && !q_status.full;

	always_comb begin
		phase_eff = start_of_file ? PH_FILE : phase_q;
		hcnt_eff  = start_of_file ? 4'd0 : hcnt_q;
		pos_eff   = start_of_file ? 32'd0 : pos_q;
		rem_eff   = start_of_file ? 32'd0 : rem_q;
		hcnt_inc  = hcnt_eff + 4'd1;

		hbuf_n = hbuf_q;
		if (hcnt_eff < rcsp_pkg::LIST_HDR_LEN) begin
			hbuf_n[{hcnt_eff, 3'b000} +: 8] = data_byte;
		end
		w0 = hbuf_n[31:0];
		w1 = hbuf_n[63:32];
		w2 = hbuf_n[95:64];

		phase_n  = phase_eff;
		hcnt_n   = hcnt_eff;
		rem_n    = rem_eff;
		hstart_n = hstart_q;
		push     = 1'b0;
		item     = '0;

		unique case (phase_eff)
			PH_WAIT: begin
			end
			PH_FILE: begin
				hcnt_n = hcnt_inc;
				if (hcnt_inc == rcsp_pkg::TAG_LEN && w0 != rcsp_pkg::TAG_RIFF) begin
					push      = 1'b1;
					item.kind = rcsp_pkg::EV_NOT_RIFF;
					phase_n   = PH_WAIT;
					hcnt_n    = 4'd0;
				end else if (hcnt_inc == rcsp_pkg::LIST_HDR_LEN) begin
					push        = 1'b1;
					item.kind   = rcsp_pkg::EV_FILE;
					item.size   = w1;
					item.offset = rcsp_pkg::DATA_OFFSET;
					item.form   = w2;
					phase_n     = PH_HEADER;
					hcnt_n      = 4'd0;
				end
			end
			PH_HEADER: begin
				hcnt_n = hcnt_inc;
				if (hcnt_eff == 4'd0) begin
					hstart_n = pos_eff;
				end
				if (hcnt_inc == rcsp_pkg::CHUNK_HDR_LEN && w0 != rcsp_pkg::TAG_LIST) begin
					push        = 1'b1;
					item.kind   = rcsp_pkg::EV_CHUNK;
					item.id     = w0;
					item.size   = w1;
					item.hstart = hstart_q;
					item.offset = hstart_q + rcsp_pkg::DATA_OFFSET;
					rem_n       = w1;
					phase_n     = (w1 == 32'd0) ? PH_HEADER : PH_PAYLOAD;
					hcnt_n      = 4'd0;
				end else if (hcnt_inc == rcsp_pkg::LIST_HDR_LEN) begin
					push        = 1'b1;
					item.kind   = rcsp_pkg::EV_LIST;
					item.id     = w0;
					item.size   = w1;
					item.form   = w2;
					item.hstart = hstart_q;
					item.offset = hstart_q + rcsp_pkg::DATA_OFFSET;
					hcnt_n      = 4'd0;
				end
			end
			PH_PAYLOAD: begin
				rem_n = rem_eff - 32'd1;
				if (emit_q) begin
					push       = 1'b1;
					item.kind  = rcsp_pkg::EV_PAYLOAD;
					item.pbyte = data_byte;
					item.plast = (rem_n == 32'd0);
				end
				if (rem_n == 32'd0) begin
					phase_n = PH_HEADER;
				end
			end
			default: begin
			end
		endcase
	end

	assign q_push = accept && push;
	assign q_item = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			pos_q    <= '0;
			hcnt_q   <= '0;
			rem_q    <= '0;
			hstart_q <= '0;
			emit_q   <= 1'b1;
		end else begin
			if (cfg_valid) begin
				emit_q <= emit_payload;
			end
			if (accept) begin
				phase_q  <= phase_n;
				pos_q    <= pos_eff + 32'd1;
				hcnt_q   <= hcnt_n;
				rem_q    <= rem_n;
				hstart_q <= hstart_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (phase_eff == PH_FILE || phase_eff == PH_HEADER)) begin
			hbuf_q <= hbuf_n;
		end
	end

endmodule

// ===== rtl/rcsp_queue.sv =====
module rcsp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rcsp_pkg::event_t    push_item,
	input  logic                pop,
	output rcsp_pkg::q_status_t status,
	output rcsp_pkg::event_t    head
);

	rcsp_pkg::event_t                  mem_q [rcsp_pkg::QUEUE_DEPTH];
	logic [rcsp_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [rcsp_pkg::QCNT_W-1:0]       count_q;

	assign status.valid = (count_q != '0);
	assign status.full  = (count_q == rcsp_pkg::QCNT_W'(rcsp_pkg::QUEUE_DEPTH));
	assign head         = mem_q[rd_ptr_q];

	function automatic logic [rcsp_pkg::QPTR_W-1:0] next_ptr(
		input logic [rcsp_pkg::QPTR_W-1:0] p);
		if (p == rcsp_pkg::QPTR_W'(rcsp_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/rcsp_back.sv =====
module rcsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rcsp_pkg::q_status_t q_status,
	input  rcsp_pkg::event_t    q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          event_kind,
	output logic [31:0]         chunk_id,
	output logic [31:0]         chunk_size,
	output logic [31:0]         chunk_offset,
	output logic [31:0]         form_type,
	output logic [3:0]          nest_depth,
	output logic [7:0]          payload_byte,
	output logic                payload_last
);

	typedef enum logic [1:0] {
		ST_TAKE = 2'b01,
		ST_POP  = 2'b10
	} state_t;

	state_t                         state_q, state_n;
	rcsp_pkg::event_t               cur_q;
	logic [31:0]                    cur_end_q;
	logic [rcsp_pkg::CNT_W-1:0]     cnt_q, cnt_n;
	logic [31:0]                    stack_q [rcsp_pkg::LIST_DEPTH];
	logic [rcsp_pkg::IDX_W-1:0]     top_idx, push_idx;
	logic                           ended;
	logic                           out_free;
	logic                           load;
	logic                           push_en;
	logic                           take_hdr;
	rcsp_pkg::event_t               ld_ev;
	logic [3:0]                     ld_nest;
	logic                           out_valid_q;
	rcsp_pkg::event_t               out_ev_q;
	logic [3:0]                     out_nest_q;

	assign out_free = !out_valid_q || !out_stall;
	assign top_idx  = rcsp_pkg::IDX_W'(cnt_q - 1'b1);
	assign push_idx = rcsp_pkg::IDX_W'(cnt_q);
	assign ended    = (cnt_q != '0) && (cur_q.hstart >= stack_q[top_idx]);

	always_comb begin
		state_n  = state_q;
		cnt_n    = cnt_q;
		q_pop    = 1'b0;
		load     = 1'b0;
		push_en  = 1'b0;
		take_hdr = 1'b0;
		ld_ev    = q_head;
		ld_nest  = 4'd0;

		unique case (state_q)
			ST_TAKE: begin
				if (q_status.valid) begin
					if (q_head.kind inside {rcsp_pkg::EV_LIST, rcsp_pkg::EV_CHUNK}) begin
						q_pop    = 1'b1;
						take_hdr = 1'b1;
						state_n  = ST_POP;
					end else if (out_free) begin
						q_pop = 1'b1;
						load  = 1'b1;
						if (q_head.kind inside {rcsp_pkg::EV_FILE, rcsp_pkg::EV_NOT_RIFF}) begin
							cnt_n = '0;
						end
					end
				end
			end
			ST_POP: begin
				if (ended) begin
					cnt_n = cnt_q - 1'b1;
				end else if (out_free) begin
					load    = 1'b1;
					ld_ev   = cur_q;
					ld_nest = 4'(cnt_q);
					state_n = ST_TAKE;
					if (cur_q.kind == rcsp_pkg::EV_LIST &&
					    cnt_q < rcsp_pkg::CNT_W'(rcsp_pkg::LIST_DEPTH)) begin
						push_en = 1'b1;
						cnt_n   = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_n = ST_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_hdr) begin
			cur_q     <= q_head;
			cur_end_q <= q_head.offset + q_head.size;
		end
		if (push_en) begin
			stack_q[push_idx] <= cur_end_q;
		end
		if (load) begin
			out_ev_q   <= ld_ev;
			out_nest_q <= ld_nest;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_ev_q.kind;
	assign chunk_id     = out_ev_q.id;
	assign chunk_size   = out_ev_q.size;
	assign chunk_offset = out_ev_q.offset;
	assign form_type    = out_ev_q.form;
	assign nest_depth   = out_nest_q;
	assign payload_byte = out_ev_q.pbyte;
	assign payload_last = out_ev_q.plast;

endmodule

// ===== rtl/riff_chunk_stream_parser.sv =====
// Channel   Direction  Handshake          Request
// in        sink       in_valid/in_stall   data_byte, start_of_file
// out       source     out_valid/out_stall event_kind, chunk_id, chunk_size, chunk_offset,
//                                          form_type, nest_depth, payload_byte, payload_last
// cfg       sink       cfg_valid/cfg_ready emit_payload
//
// The front takes one byte per cycle while the two-entry event queue has room;
// in_stall is high exactly when that queue is full.
// The back moves a payload, file or not-RIFF event from the queue head into the output register when it is free.
// A chunk or list header is taken into a holding register in ST_TAKE; ST_POP then pops every ended list,
// checking the list stack one entry per cycle at its top, before the header is loaded for output.
// Reset is asynchronous and immediate; there is no clearing pass, and the stack
// entries hold nothing meaningful until pushed.
// out_stall holds the output register and the back's loads into it; the queue absorbs short stalls.
module riff_chunk_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [31:0] chunk_id,
	output logic [31:0] chunk_size,
	output logic [31:0] chunk_offset,
	output logic [31:0] form_type,
	output logic [3:0]  nest_depth,
	output logic [7:0]  payload_byte,
	output logic        payload_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        emit_payload
);

	rcsp_pkg::q_status_t q_status;
	rcsp_pkg::event_t    q_item;
	rcsp_pkg::event_t    q_head;
	logic                q_push;
	logic                q_pop;

	// Front: assemble header bytes, classify, count payload, drop skipped bytes
	rcsp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.emit_payload  (emit_payload),
		.q_status      (q_status),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	// Queue: decouple byte intake from stack walking and output stalls
	rcsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.status    (q_status),
		.head      (q_head)
	);

	// Back: pop ended lists, push new list ends, drive the output register
	rcsp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.chunk_id     (chunk_id),
		.chunk_size   (chunk_size),
		.chunk_offset (chunk_offset),
		.form_type    (form_type),
		.nest_depth   (nest_depth),
		.payload_byte (payload_byte),
		.payload_last (payload_last)
	);

endmodule

// ===== rtl/rcsp_checker.sv =====
module rcsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_kind,
	input logic [31:0] chunk_id,
	input logic [31:0] chunk_offset,
	input logic [31:0] form_type,
	input logic [3:0]  nest_depth
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(chunk_id))
		else $error("stalled result changed");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == rcsp_pkg::EV_PAYLOAD |->
			chunk_id == 32'd0 && form_type == 32'd0 && nest_depth == 4'd0)
		else $error("payload result carries header fields");

	a_file_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == rcsp_pkg::EV_FILE |->
			chunk_offset == rcsp_pkg::DATA_OFFSET && chunk_id == 32'd0 && nest_depth == 4'd0)
		else $error("file header result malformed");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nest_depth <= 4'(rcsp_pkg::LIST_DEPTH) &&
			(event_kind == rcsp_pkg::EV_FILE || event_kind == rcsp_pkg::EV_LIST ||
			 event_kind == rcsp_pkg::EV_CHUNK || event_kind == rcsp_pkg::EV_PAYLOAD ||
			 event_kind == rcsp_pkg::EV_NOT_RIFF))
		else $error("nest depth or event kind out of range");

endmodule

bind riff_chunk_stream_parser rcsp_checker u_rcsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.event_kind   (event_kind),
	.chunk_id     (chunk_id),
	.chunk_offset (chunk_offset),
	.form_type    (form_type),
	.nest_depth   (nest_depth)
);
